// ===== src/mnc_pkg.sv =====
`timescale 1ns / 1ps

package mnc_pkg;

  // Default table bound: largest sum that the binomial store covers
  localparam int MAX_SUM_DEF = 63;

  localparam int PART_W = 7;
  localparam int PROD_W = 63;

  // Saturated product value, 2^63 - 1
  localparam logic [PROD_W-1:0] PROD_MAX = '1;

  // Held error codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_RANGE = 2'd1;
  localparam status_t STAT_OVF   = 2'd2;

  typedef struct packed {
    logic [PART_W-1:0] part;
    logic              last;
  } in_beat_t;

  typedef struct packed {
    logic [PROD_W-1:0] product;
    status_t           status;
    logic              done_res;
  } out_beat_t;

  typedef enum logic [6:0] {
    S_FILL  = 7'b0000001,
    S_DRAIN = 7'b0000010,
    S_IDLE  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

// ===== src/multinomial_coefficient_unit.sv =====
`timescale 1ns / 1ps
// An accepted part goes through the READ, MUL, ADD and DONE states before its result beat
//   is loaded (only DONE on the held-error or sum-beyond-bound path, which skips the table
//   read and the multiply). Input stalls until then, through the registered binomial store
//   read, the split 63x63 multiply over three stages and the running-product loop.
// Reset: sum, product and error clear; the binomial store is then rebuilt row by row,
//   one entry a cycle, and input is stalled until the fill and its drain state are done.
module multinomial_coefficient_unit #(
  parameter int MAX_SUM = mnc_pkg::MAX_SUM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mnc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mnc_pkg::out_beat_t out_data
);

  localparam int DEPTH = ((MAX_SUM + 1) * (MAX_SUM + 2)) / 2;
  localparam int AW = $clog2(DEPTH);
  localparam logic [6:0] MAX_SUM_V = 7'(MAX_SUM);

  // Binomial store and its read register
  logic [62:0] mem [DEPTH];
  logic [62:0] rd_data_r;
  logic [AW-1:0] raddr;

  mnc_pkg::state_t state_r, state_nxt;

  // Running multinomial state
  logic [6:0]  sum_r, sum_nxt;
  logic [62:0] prod_r, prod_nxt;
  mnc_pkg::status_t err_r, err_nxt;
  logic        last_r, last_nxt;

  // Fill sequencer
  logic [6:0]    fn_r, fn_nxt;
  logic [6:0]    fk_r, fk_nxt;
  logic [AW-1:0] fbase_r, fbase_nxt;
  logic [AW-1:0] pbase_r, pbase_nxt;
  logic          fill_issue;

  // Fill write stage
  logic          p_valid_r;
  logic [AW-1:0] p_addr_r;
  logic          p_zero_r, p_one_r, p_first_r;
  logic [62:0]   hold_r;
  logic [62:0]   above, left, wdata;

  // Split multiplier
  logic [63:0] ll_r;
  logic [62:0] lh_r, hl_r;
  logic        hh_nz_r;
  logic [63:0] mid_r;
  logic [95:0] total;
  logic        ovf;

  // Lookup address and sum checks
  logic [7:0]    sum_wide;
  logic [6:0]    sum_sat;
  logic          range_err;
  logic [13:0]   tri_prod;
  logic [AW-1:0] look_addr;
  logic          accept;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  mnc_pkg::out_beat_t out_data_r;

  assign in_stall  = (state_r != mnc_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sum_wide  = {1'b0, sum_r} + {1'b0, in_data.part};
  assign sum_sat   = sum_wide[7] ? 7'h7F : sum_wide[6:0];
  assign range_err = (sum_wide > {1'b0, MAX_SUM_V});
  // row base n*(n+1)/2 of the new sum
  assign tri_prod  = 14'(sum_wide[6:0]) * (14'(sum_wide[6:0]) + 14'd1);
  assign look_addr = AW'(tri_prod[13:1] + 13'(in_data.part));

  assign raddr = (state_r == mnc_pkg::S_FILL) ? (pbase_r + AW'(fk_r)) : look_addr;

  // Fill write value: entry above plus entry above-left; the entry above the
  // leftmost one of a row is always one, so it is not taken from the store
  assign above = p_zero_r ? 63'd0 : (p_first_r ? 63'd1 : rd_data_r);
  assign left  = p_first_r ? 63'd0 : hold_r;
  assign wdata = p_one_r ? 63'd1 : (above + left);

  // Final partial product sum; overflow if anything lands at bit 63 or above
  assign total = {32'd0, ll_r} + {mid_r, 32'd0};
  assign ovf   = hh_nz_r || (|total[95:63]);

  // Control and running state
  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    prod_nxt   = prod_r;
    err_nxt    = err_r;
    last_nxt   = last_r;
    fn_nxt     = fn_r;
    fk_nxt     = fk_r;
    fbase_nxt  = fbase_r;
    pbase_nxt  = pbase_r;
    fill_issue = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      mnc_pkg::S_FILL: begin
        fill_issue = 1'b1;
        if (fk_r == fn_r) begin
          if (fn_r == MAX_SUM_V) begin
            state_nxt = mnc_pkg::S_DRAIN;
          end else begin
            fn_nxt    = fn_r + 7'd1;
            fk_nxt    = 7'd0;
            pbase_nxt = fbase_r;
            fbase_nxt = fbase_r + AW'(fn_r) + AW'(1);
          end
        end else begin
          fk_nxt = fk_r + 7'd1;
        end
      end
      mnc_pkg::S_DRAIN: begin
        state_nxt = mnc_pkg::S_IDLE;
      end
      mnc_pkg::S_IDLE: begin
        if (accept) begin
          last_nxt = in_data.last;
          if (err_r != mnc_pkg::STAT_OK) begin
            sum_nxt   = sum_sat;
            prod_nxt  = mnc_pkg::PROD_MAX;
            state_nxt = mnc_pkg::S_DONE;
          end else if (range_err) begin
            err_nxt   = mnc_pkg::STAT_RANGE;
            sum_nxt   = sum_sat;
            prod_nxt  = mnc_pkg::PROD_MAX;
            state_nxt = mnc_pkg::S_DONE;
          end else begin
            sum_nxt   = sum_wide[6:0];
            state_nxt = mnc_pkg::S_READ;
          end
        end
      end
      mnc_pkg::S_READ: begin
        state_nxt = mnc_pkg::S_MUL;
      end
      mnc_pkg::S_MUL: begin
        state_nxt = mnc_pkg::S_ADD;
      end
      mnc_pkg::S_ADD: begin
        if (ovf) begin
          err_nxt  = mnc_pkg::STAT_OVF;
          prod_nxt = mnc_pkg::PROD_MAX;
        end else begin
          prod_nxt = total[62:0];
        end
        state_nxt = mnc_pkg::S_DONE;
      end
      mnc_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = mnc_pkg::S_IDLE;
          if (last_r) begin
            sum_nxt  = 7'd0;
            prod_nxt = 63'd1;
            err_nxt  = mnc_pkg::STAT_OK;
          end
        end
      end
      default: begin
        state_nxt = mnc_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mnc_pkg::S_FILL;
      sum_r       <= 7'd0;
      prod_r      <= 63'd1;
      err_r       <= mnc_pkg::STAT_OK;
      last_r      <= 1'b0;
      fn_r        <= 7'd0;
      fk_r        <= 7'd0;
      fbase_r     <= '0;
      pbase_r     <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      prod_r      <= prod_nxt;
      err_r       <= err_nxt;
      last_r      <= last_nxt;
      fn_r        <= fn_nxt;
      fk_r        <= fk_nxt;
      fbase_r     <= fbase_nxt;
      pbase_r     <= pbase_nxt;
      p_valid_r   <= fill_issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Store: one write port for the fill, one registered read port
  always_ff @(posedge clk) begin
    if (p_valid_r) begin
      mem[p_addr_r] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  // Fill write stage payload
  always_ff @(posedge clk) begin
    p_addr_r  <= fbase_r + AW'(fk_r);
    p_zero_r  <= (fk_r == fn_r);
    p_one_r   <= (fn_r == 7'd0);
    p_first_r <= (fk_r == 7'd0);
    if (p_valid_r) begin
      hold_r <= above;
    end
  end

  // Multiply: 32-bit low and 31-bit high halves, high x high only checked for zero
  always_ff @(posedge clk) begin
    if (state_r == mnc_pkg::S_READ) begin
      ll_r    <= 64'(prod_r[31:0]) * 64'(rd_data_r[31:0]);
      lh_r    <= 63'(prod_r[31:0]) * 63'(rd_data_r[62:32]);
      hl_r    <= 63'(prod_r[62:32]) * 63'(rd_data_r[31:0]);
      hh_nz_r <= (|prod_r[62:32]) && (|rd_data_r[62:32]);
    end
    if (state_r == mnc_pkg::S_MUL) begin
      mid_r <= {1'b0, lh_r} + {1'b0, hl_r};
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.product  <= prod_r;
      out_data_r.status   <= err_r;
      out_data_r.done_res <= last_r;
    end
  end

  // A clean running product is never zero (every binomial is at least one)
  a_prod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r == mnc_pkg::STAT_OK) |-> (prod_r != 63'd0))
    else $error("running product zero without error");

  // A held error always comes with a saturated product
  a_err_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != mnc_pkg::STAT_OK) |-> (prod_r == mnc_pkg::PROD_MAX))
    else $error("error held without saturated product");

  // Without an error the running sum stays inside the table
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r == mnc_pkg::STAT_OK) |-> (sum_r <= MAX_SUM_V))
    else $error("running sum beyond table bound without error");

  // Fill writes stay inside the store
  a_fill_addr: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (32'(p_addr_r) < DEPTH))
    else $error("fill write outside store");

  // A new result beat is only produced from the result state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load) |=> (out_valid_r && $past(state_r == mnc_pkg::S_DONE)))
    else $error("result beat loaded outside result state");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int SUM_BOUND = mnc_pkg::MAX_SUM_DEF;
  localparam int HOLD_CYC  = 400;
  localparam int MAX_GAP   = 40;

  // one row of the directed table; typed rows carry their own expected beat
  typedef struct {
    int                         part;
    bit                         last;
    bit                         typed;
    logic [mnc_pkg::PROD_W-1:0] prod;
    mnc_pkg::status_t           st;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mnc_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mnc_pkg::out_beat_t out_data;

  // binomials and the running multinomial state of the predictor
  logic [63:0]                binom_tab [0:SUM_BOUND][0:SUM_BOUND];
  int                         acc_sum;
  logic [mnc_pkg::PROD_W-1:0] acc_prod;
  mnc_pkg::status_t           acc_err;

  mnc_pkg::out_beat_t coeff_q[$];
  dir_row_t           dir_tab[$];
  int                 err_cnt = 0;
  int                 gap_pct = 0;
  int                 stall_pct = 0;
  bit                 hold_req = 1'b0;
  int                 hold_cnt = 0;

  multinomial_coefficient_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // advance the running multinomial by one part, return the beat it yields
  function automatic mnc_pkg::out_beat_t next_coefficient(mnc_pkg::in_beat_t b);
    mnc_pkg::out_beat_t r;
    int                 s;
    logic [63:0]        c;
    logic [63:0]        p;
    s = acc_sum + int'(b.part);
    if (acc_err == mnc_pkg::STAT_OK) begin
      if (s > SUM_BOUND) begin
        acc_err  = mnc_pkg::STAT_RANGE;
        acc_prod = mnc_pkg::PROD_MAX;
        acc_sum  = (s > 127) ? 127 : s;
      end else begin
        c       = binom_tab[s][b.part];
        acc_sum = s;
        if (c != 0 && {1'b0, acc_prod} > {1'b0, mnc_pkg::PROD_MAX} / c) begin
          acc_err  = mnc_pkg::STAT_OVF;
          acc_prod = mnc_pkg::PROD_MAX;
        end else begin
          p        = {1'b0, acc_prod} * c;
          acc_prod = p[mnc_pkg::PROD_W-1:0];
        end
      end
    end else begin
      acc_sum  = (s > 127) ? 127 : s;
      acc_prod = mnc_pkg::PROD_MAX;
    end
    r.product  = acc_prod;
    r.status   = acc_err;
    r.done_res = b.last;
    if (b.last) begin
      acc_sum  = 0;
      acc_prod = 63'd1;
      acc_err  = mnc_pkg::STAT_OK;
    end
    return r;
  endfunction

  // offer one beat, hold it until taken, then queue its expected result
  task automatic send_part(int part, bit last, bit typed, mnc_pkg::out_beat_t want);
    int                 gap;
    mnc_pkg::in_beat_t  b;
    mnc_pkg::out_beat_t pred;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < gap_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    b.part = part[mnc_pkg::PART_W-1:0];
    b.last = last;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = next_coefficient(b);
    coeff_q.push_back(typed ? want : pred);
  endtask

  task automatic add_row(int part, bit last, bit typed,
                         logic [mnc_pkg::PROD_W-1:0] prod, mnc_pkg::status_t st);
    dir_row_t r;
    r.part  = part;
    r.last  = last;
    r.typed = typed;
    r.prod  = prod;
    r.st    = st;
    dir_tab.push_back(r);
  endtask

  // random multinomials: mostly well formed, some overflow prone, some noise
  task automatic run_sequences(int n_items);
    int                 sent;
    int                 kind;
    int                 nparts;
    int                 budget;
    int                 lim;
    int                 part;
    bit                 last;
    mnc_pkg::out_beat_t none;
    sent = 0;
    none = '0;
    while (sent < n_items) begin
      kind   = $urandom_range(0, 99);
      nparts = $urandom_range(1, 6);
      budget = SUM_BOUND;
      for (int i = 0; i < nparts; i++) begin
        last = (i == nparts - 1);
        if (kind < 70) begin
          lim  = (budget < 12) ? budget : 12;
          part = ($urandom_range(0, 3) == 0) ? $urandom_range(0, budget)
                                             : $urandom_range(0, lim);
          budget -= part;
        end else if (kind < 85) begin
          part = $urandom_range(15, 35);
        end else begin
          part = $urandom_range(0, 66);
          last = ($urandom_range(0, 3) == 0);
        end
        send_part(part, last, 1'b0, none);
        sent++;
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin : chk_results
    mnc_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (coeff_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data.product), 64'd0);
      end else begin
        want = coeff_q.pop_front();
        if (out_data.product !== want.product)
          report_mismatch("product", 64'(out_data.product), 64'(want.product));
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.done_res !== want.done_res)
          report_mismatch("done_res", 64'(out_data.done_res), 64'(want.done_res));
      end
    end
  end

  // receiver: long hold-off once on request, otherwise random stalls
  always @(negedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYC) begin
      hold_cnt  <= hold_cnt + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    #1_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    mnc_pkg::out_beat_t want;
    int                 waited;

    // Pascal triangle for the predictor
    for (int n = 0; n <= SUM_BOUND; n++)
      for (int k = 0; k <= SUM_BOUND; k++)
        binom_tab[n][k] = (k > n) ? 64'd0 :
                          (k == 0 || k == n) ? 64'd1 :
                          binom_tab[n-1][k] + binom_tab[n-1][k-1];
    acc_sum  = 0;
    acc_prod = 63'd1;
    acc_err  = mnc_pkg::STAT_OK;

    // directed table
    add_row(0,  1'b1, 1'b1, 63'd1,   mnc_pkg::STAT_OK);     // zero part alone
    add_row(63, 1'b1, 1'b1, 63'd1,   mnc_pkg::STAT_OK);     // sum right at the bound
    add_row(64, 1'b1, 1'b1, mnc_pkg::PROD_MAX, mnc_pkg::STAT_RANGE); // sum beyond bound
    add_row(66, 1'b0, 1'b1, mnc_pkg::PROD_MAX, mnc_pkg::STAT_RANGE);
    add_row(66, 1'b0, 1'b1, mnc_pkg::PROD_MAX, mnc_pkg::STAT_RANGE); // held range error
    add_row(5,  1'b1, 1'b1, mnc_pkg::PROD_MAX, mnc_pkg::STAT_RANGE);
    add_row(1,  1'b0, 1'b1, 63'd1,   mnc_pkg::STAT_OK);
    add_row(1,  1'b0, 1'b1, 63'd2,   mnc_pkg::STAT_OK);
    add_row(1,  1'b1, 1'b1, 63'd6,   mnc_pkg::STAT_OK);
    add_row(21, 1'b0, 1'b1, 63'd1,   mnc_pkg::STAT_OK);
    add_row(21, 1'b0, 1'b0, '0,      mnc_pkg::STAT_OK);
    add_row(21, 1'b0, 1'b1, mnc_pkg::PROD_MAX, mnc_pkg::STAT_OVF);   // product overflow
    add_row(0,  1'b0, 1'b1, mnc_pkg::PROD_MAX, mnc_pkg::STAT_OVF);   // held overflow
    add_row(40, 1'b1, 1'b1, mnc_pkg::PROD_MAX, mnc_pkg::STAT_OVF);   // held code, big sum
    add_row(31, 1'b0, 1'b1, 63'd1,   mnc_pkg::STAT_OK);
    add_row(32, 1'b1, 1'b0, '0,      mnc_pkg::STAT_OK);
    add_row(42, 1'b0, 1'b1, 63'd1,   mnc_pkg::STAT_OK);
    add_row(21, 1'b1, 1'b0, '0,      mnc_pkg::STAT_OK);
    add_row(0,  1'b0, 1'b1, 63'd1,   mnc_pkg::STAT_OK);
    add_row(0,  1'b0, 1'b1, 63'd1,   mnc_pkg::STAT_OK);
    add_row(63, 1'b0, 1'b1, 63'd1,   mnc_pkg::STAT_OK);
    add_row(1,  1'b1, 1'b1, mnc_pkg::PROD_MAX, mnc_pkg::STAT_RANGE);
    add_row(10, 1'b0, 1'b0, '0,      mnc_pkg::STAT_OK);
    add_row(53, 1'b1, 1'b0, '0,      mnc_pkg::STAT_OK);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      want.product  = dir_tab[i].prod;
      want.status   = dir_tab[i].st;
      want.done_res = dir_tab[i].last;
      send_part(dir_tab[i].part, dir_tab[i].last, dir_tab[i].typed, want);
    end

    // random phases with varied input gap and output stall rates
    gap_pct = 0;  stall_pct = 0;  run_sequences(300);
    gap_pct = 84; stall_pct = 0;  run_sequences(280);
    gap_pct = 0;  stall_pct = 84; run_sequences(280);
    gap_pct = 24; stall_pct = 24; run_sequences(300);
    // back pressure: receiver holds off while the sender keeps offering
    gap_pct = 0;  stall_pct = 0;  hold_req = 1'b1;
    run_sequences(270);

    @(negedge clk);
    in_valid <= 1'b0;
    while (coeff_q.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < 20) begin
      @(posedge clk);
      waited++;
    end

    if (err_cnt == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
